>>> hdl/sdc_pkg.sv
package sdc_pkg;

  // Fixed field widths
  localparam int COORD_W  = 6;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 38;
  localparam int STEP_W   = 4;
  localparam int DIM_W    = 7;
  localparam int TAP_W    = 3;
  localparam int REACH_W  = 10;
  localparam int PROD_W   = 2 * SAMPLE_W;

  // Register bounds
  localparam int STEP_HIGH       = 8;
  localparam int IMAGE_DIM_HIGH  = 64;
  localparam int KERNEL_DIM_HIGH = 8;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_IMAGE_DIM  = 64;
  localparam int DEF_MAX_KERNEL_DIM = 8;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_LOAD_KERNEL = 2'd0,
    CMD_LOAD_IMAGE  = 2'd1,
    CMD_COMPUTE     = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STRIDE_COLS   = 3'd0,
    REG_STRIDE_ROWS   = 3'd1,
    REG_DILATION_COLS = 3'd2,
    REG_DILATION_ROWS = 3'd3,
    REG_IMAGE_ROWS    = 3'd4,
    REG_IMAGE_COLS    = 3'd5,
    REG_KERNEL_ROWS   = 3'd6,
    REG_KERNEL_COLS   = 3'd7
  } cfg_reg_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

  // Map zero to one and cap at the bound
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] high);
    if (v == '0) return DIM_W'(1);
    else if (v > high) return high;
    else return v;
  endfunction

endpackage

>>> hdl/strided_dilated_conv2d.sv
// Channel  | Dir | Handshake                  | Payload
// s_*      | in  | s_tvalid / s_tready        | s_tuser: cmd; s_tdata: row, col, sample
// m_*      | out | m_tvalid / m_tready        | m_tdata: conv_sum; m_tuser: range_error
// cfg_*    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A load beat writes the store on the accepting edge.
// A compute beat runs a setup step, then walks one tap per cycle through the
// single read port of each store, then drains the store read, product and
// accumulate registers; a range error skips the walk and goes to the drain step.
// Reset is synchronous and restores the register defaults; stores are not cleared.
// The result sits in an output register, so loads are taken while it waits;
// the next compute finishes and holds in its drain step until that register frees.
module strided_dilated_conv2d #(
  parameter int MAX_IMAGE_DIM  = sdc_pkg::DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNEL_DIM = sdc_pkg::DEF_MAX_KERNEL_DIM
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // row_index[5:0], col_index[11:6], sample_value[27:12]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // conv_sum[37:0]
  output logic        m_tuser,   // range_error[0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import sdc_pkg::*;

  localparam int IMG_HIGH = (IMAGE_DIM_HIGH < MAX_IMAGE_DIM) ? IMAGE_DIM_HIGH : MAX_IMAGE_DIM;
  localparam int KER_HIGH = (KERNEL_DIM_HIGH < MAX_KERNEL_DIM) ? KERNEL_DIM_HIGH
                                                              : MAX_KERNEL_DIM;
  localparam int IDEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int KDEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
  localparam int IAW    = $clog2(IDEPTH);
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN, ST_DRAIN} state_t;

  state_t state;

  // Configuration registers
  logic [STEP_W-1:0] stride_cols, stride_rows, dilation_cols, dilation_rows;
  logic [DIM_W-1:0]  image_rows, image_cols;
  logic [STEP_W-1:0] kernel_rows, kernel_cols;

  // Input fields
  logic [COORD_W-1:0]         in_row, in_col;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_accept;

  // Compute context
  logic [COORD_W-1:0] pos_row, pos_col;
  logic [COORD_W-1:0] base_r, yr, xc;
  logic [TAP_W-1:0]   ki, kj, kr_last, kc_last;
  logic [STEP_W-1:0]  dr, dc;
  logic               err;
  logic               rd_valid;
  logic               emit;

  // Stores
  logic signed [SAMPLE_W-1:0] image_mem  [IDEPTH];
  logic signed [SAMPLE_W-1:0] kernel_mem [KDEPTH];
  logic signed [SAMPLE_W-1:0] img_rdata, ker_rdata;
  logic                       img_we, ker_we;
  logic [IAW-1:0]             img_waddr, img_raddr;
  logic [KAW-1:0]             ker_waddr, ker_raddr;

  // Setup arithmetic
  logic [STEP_W-1:0]  sr_c, sc_c, dr_c, dc_c, kr_c, kc_c;
  logic [DIM_W-1:0]   ir_c, ic_c;
  logic [REACH_W-1:0] base_r_full, base_c_full, reach_r, reach_c;
  logic               err_c;

  mac_ctrl_t                  mac_ctrl;
  logic signed [SUM_W-1:0]    acc;
  logic                       mac_busy;

  assign in_row    = s_tdata[5:0];
  assign in_col    = s_tdata[11:6];
  assign in_sample = s_tdata[27:12];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Decode load commands into store writes
  assign ker_we = in_accept && (s_tuser == CMD_LOAD_KERNEL) &&
                  (32'(in_row) < MAX_KERNEL_DIM) && (32'(in_col) < MAX_KERNEL_DIM);
  assign img_we = in_accept && (s_tuser == CMD_LOAD_IMAGE) &&
                  (32'(in_row) < MAX_IMAGE_DIM) && (32'(in_col) < MAX_IMAGE_DIM);
  assign ker_waddr = KAW'(32'(in_row) * MAX_KERNEL_DIM + 32'(in_col));
  assign img_waddr = IAW'(32'(in_row) * MAX_IMAGE_DIM + 32'(in_col));
  assign ker_raddr = KAW'(32'(ki) * MAX_KERNEL_DIM + 32'(kj));
  assign img_raddr = IAW'(32'(yr) * MAX_IMAGE_DIM + 32'(xc));

  // Store ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (img_we) image_mem[img_waddr] <= in_sample;
    img_rdata <= image_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (ker_we) kernel_mem[ker_waddr] <= in_sample;
    ker_rdata <= kernel_mem[ker_raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stride_cols   <= STEP_W'(1);
      stride_rows   <= STEP_W'(1);
      dilation_cols <= STEP_W'(1);
      dilation_rows <= STEP_W'(1);
      image_rows    <= DIM_W'(64);
      image_cols    <= DIM_W'(64);
      kernel_rows   <= STEP_W'(3);
      kernel_cols   <= STEP_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STRIDE_COLS:   stride_cols   <= cfg_data[STEP_W-1:0];
        REG_STRIDE_ROWS:   stride_rows   <= cfg_data[STEP_W-1:0];
        REG_DILATION_COLS: dilation_cols <= cfg_data[STEP_W-1:0];
        REG_DILATION_ROWS: dilation_rows <= cfg_data[STEP_W-1:0];
        REG_IMAGE_ROWS:    image_rows    <= cfg_data;
        REG_IMAGE_COLS:    image_cols    <= cfg_data;
        REG_KERNEL_ROWS:   kernel_rows   <= cfg_data[STEP_W-1:0];
        REG_KERNEL_COLS:   kernel_cols   <= cfg_data[STEP_W-1:0];
      endcase
    end
  end

  // Clamp registers and check the dilated kernel against the image
  always_comb begin
    sr_c = STEP_W'(clamp_dim(DIM_W'(stride_rows), DIM_W'(STEP_HIGH)));
    sc_c = STEP_W'(clamp_dim(DIM_W'(stride_cols), DIM_W'(STEP_HIGH)));
    dr_c = STEP_W'(clamp_dim(DIM_W'(dilation_rows), DIM_W'(STEP_HIGH)));
    dc_c = STEP_W'(clamp_dim(DIM_W'(dilation_cols), DIM_W'(STEP_HIGH)));
    kr_c = STEP_W'(clamp_dim(DIM_W'(kernel_rows), DIM_W'(KER_HIGH)));
    kc_c = STEP_W'(clamp_dim(DIM_W'(kernel_cols), DIM_W'(KER_HIGH)));
    ir_c = clamp_dim(image_rows, DIM_W'(IMG_HIGH));
    ic_c = clamp_dim(image_cols, DIM_W'(IMG_HIGH));
    base_r_full = REACH_W'(pos_row) * REACH_W'(sr_c);
    base_c_full = REACH_W'(pos_col) * REACH_W'(sc_c);
    reach_r = base_r_full + REACH_W'(kr_c - STEP_W'(1)) * REACH_W'(dr_c);
    reach_c = base_c_full + REACH_W'(kc_c - STEP_W'(1)) * REACH_W'(dc_c);
    err_c = (reach_r >= REACH_W'(ir_c)) || (reach_c >= REACH_W'(ic_c));
  end

  assign mac_ctrl.clear = (state == ST_SETUP);
  assign mac_ctrl.valid = rd_valid;

  // Result is ready and the output register is free or freeing
  assign emit = (state == ST_DRAIN) && !rd_valid && !mac_busy && (!m_tvalid || m_tready);

  sdc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .tap  (ker_rdata),
    .pix  (img_rdata),
    .acc  (acc),
    .busy (mac_busy)
  );

  // Sequencer: setup, walk the taps column by column, drain, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_RUN);
      if (m_tvalid && m_tready && !emit) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (s_tuser == CMD_COMPUTE)) begin
            pos_row <= in_row;
            pos_col <= in_col;
            state   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          err     <= err_c;
          base_r  <= base_r_full[COORD_W-1:0];
          yr      <= base_r_full[COORD_W-1:0];
          xc      <= base_c_full[COORD_W-1:0];
          dr      <= dr_c;
          dc      <= dc_c;
          kr_last <= TAP_W'(kr_c - STEP_W'(1));
          kc_last <= TAP_W'(kc_c - STEP_W'(1));
          ki      <= '0;
          kj      <= '0;
          state   <= err_c ? ST_DRAIN : ST_RUN;
        end
        ST_RUN: begin
          if (ki == kr_last) begin
            ki <= '0;
            yr <= base_r;
            if (kj == kc_last) begin
              state <= ST_DRAIN;
            end else begin
              kj <= kj + TAP_W'(1);
              xc <= xc + COORD_W'(dc);
            end
          end else begin
            ki <= ki + TAP_W'(1);
            yr <= yr + COORD_W'(dr);
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(40-SUM_W)'(0), (err ? SUM_W'(0) : acc)};
            m_tuser  <= err;
            state    <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Reads are issued only while walking the taps
  a_rd_from_run: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state == ST_RUN))
    else $error("store read data without a tap issue");

  // No accumulation in flight while new beats are taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_valid && !mac_busy))
    else $error("pipeline busy in idle");

  // Tap counters stay inside the kernel in use
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (ki <= kr_last && kj <= kc_last))
    else $error("tap counter out of range");

  // A range error carries a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("range error with nonzero sum");

endmodule

>>> hdl/sdc_mac.sv
module sdc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  sdc_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [sdc_pkg::SAMPLE_W-1:0] tap,
  input  logic signed [sdc_pkg::SAMPLE_W-1:0] pix,
  output logic signed [sdc_pkg::SUM_W-1:0]    acc,
  output logic                                busy
);
  import sdc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  // Track a product in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
    end
  end

  // Register the product, then add it into the running sum
  always_ff @(posedge clk) begin
    prod <= tap * pix;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign busy = prod_valid;

endmodule
